>>> hdl/pan_tilt_centroid_tracker_macros.svh
// Assertion macros shared by the tracker RTL.
`ifndef PAN_TILT_CENTROID_TRACKER_MACROS_SVH
`define PAN_TILT_CENTROID_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define PTCT_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ptct assertion failed");
`define PTCT_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ptct assertion failed");
`else
`define PTCT_ASSERT(name, clk, rst, prop)
`define PTCT_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> hdl/ptct_pkg.sv
package ptct_pkg;

  localparam int COORD_W        = 12;
  localparam int MAX_POINTS_DEF = 1024;
  localparam int CFG_IDX_W      = 2;
  localparam int STEP_CNT_W     = $clog2(COORD_W);

  localparam logic [COORD_W-1:0] STEP_SIZE_RST    = 12'd8;
  localparam logic [COORD_W-1:0] DEAD_RADIUS_RST  = 12'd40;
  localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [COORD_W-1:0] TRACK_X_RST      = 12'd320;
  localparam logic [COORD_W-1:0] TRACK_Y_RST      = 12'd240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE    = 2'd0,
    REG_DEAD_RADIUS  = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_LEFT  = 3'd1,
    CMD_RIGHT = 3'd2,
    CMD_UP    = 3'd3,
    CMD_DOWN  = 3'd4
  } move_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] box_min_x;
    logic [COORD_W-1:0] box_min_y;
    logic [COORD_W-1:0] box_max_x;
    logic [COORD_W-1:0] box_max_y;
    logic               point_valid;
    logic [COORD_W-1:0] fixed_x;
    logic [COORD_W-1:0] fixed_y;
    logic [COORD_W-1:0] moving_x;
    logic [COORD_W-1:0] moving_y;
    logic               last_of_box;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] centre_x;
    logic [COORD_W-1:0] centre_y;
    move_cmd_t          move_cmd;
  } result_t;

  typedef struct packed {
    logic accum;
    logic div_load;
    logic div_step;
    logic apply;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic count_zero;
  } dp_status_t;

  function automatic logic [COORD_W-1:0] approach(
    input logic [COORD_W-1:0] cur,
    input logic [COORD_W-1:0] target,
    input logic [COORD_W-1:0] step
  );
    logic [COORD_W:0]   up;
    logic [COORD_W:0]   dn;
    logic [COORD_W-1:0] r;
    up = {1'b0, cur} + {1'b0, step};
    dn = {1'b0, cur} - {1'b0, step};
    if (target > cur) begin
      r = (up > {1'b0, target}) ? target : up[COORD_W-1:0];
    end else begin
      r = (dn[COORD_W] || (dn[COORD_W-1:0] < target)) ? target : dn[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/ptct_ctrl.sv
`include "pan_tilt_centroid_tracker_macros.svh"

module ptct_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 last_of_box,
  input  ptct_pkg::dp_status_t status,
  output logic                 busy,
  output ptct_pkg::ctrl_t      ctl
);

  ptct_pkg::state_t                     state;
  ptct_pkg::state_t                     state_next;
  logic [ptct_pkg::STEP_CNT_W-1:0]      step_cnt;
  logic                                 div_last;

  assign div_last = (step_cnt == ptct_pkg::STEP_CNT_W'(ptct_pkg::COORD_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ptct_pkg::ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ptct_pkg::ST_LOAD) begin
        step_cnt <= '0;
      end else if (state == ptct_pkg::ST_DIV) begin
        step_cnt <= step_cnt + ptct_pkg::STEP_CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ptct_pkg::ST_IDLE: begin
        if (start && last_of_box) state_next = ptct_pkg::ST_LOAD;
      end
      ptct_pkg::ST_LOAD: begin
        state_next = status.count_zero ? ptct_pkg::ST_EMIT : ptct_pkg::ST_DIV;
      end
      ptct_pkg::ST_DIV: begin
        if (div_last) state_next = ptct_pkg::ST_APPLY;
      end
      ptct_pkg::ST_APPLY: begin
        state_next = ptct_pkg::ST_EMIT;
      end
      ptct_pkg::ST_EMIT: begin
        state_next = ptct_pkg::ST_IDLE;
      end
      default: begin
        state_next = ptct_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state)
      ptct_pkg::ST_IDLE: begin
        busy      = 1'b0;
        ctl.accum = start;
      end
      ptct_pkg::ST_LOAD: begin
        ctl.div_load = !status.count_zero;
      end
      ptct_pkg::ST_DIV: begin
        ctl.div_step = 1'b1;
      end
      ptct_pkg::ST_APPLY: begin
        ctl.apply = 1'b1;
      end
      ptct_pkg::ST_EMIT: begin
        ctl.emit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `PTCT_ASSERT(a_close_to_load, clk, rst, (state == ptct_pkg::ST_IDLE && start && last_of_box) |=> (state == ptct_pkg::ST_LOAD))
  `PTCT_ASSERT(a_div_bounded, clk, rst, (state == ptct_pkg::ST_DIV) |-> (step_cnt < ptct_pkg::STEP_CNT_W'(ptct_pkg::COORD_W)))
  `PTCT_ASSERT(a_emit_to_idle, clk, rst, (state == ptct_pkg::ST_EMIT) |=> (state == ptct_pkg::ST_IDLE))

endmodule

>>> hdl/ptct_dp.sv
`include "pan_tilt_centroid_tracker_macros.svh"

module ptct_dp #(
  parameter int MAX_POINTS = ptct_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ptct_pkg::item_t                    item,
  input  ptct_pkg::ctrl_t                    ctl,
  input  logic                               cfg_valid,
  input  logic [ptct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptct_pkg::COORD_W-1:0]       cfg_data,
  output ptct_pkg::dp_status_t               status,
  output ptct_pkg::result_t                  result,
  output logic                               result_valid
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int W  = ptct_pkg::COORD_W;
  localparam int SW = W + CW;

  logic [W-1:0]  step_size;
  logic [W-1:0]  dead_radius;
  logic [W-1:0]  frame_width;
  logic [W-1:0]  frame_height;
  logic [W-1:0]  track_x;
  logic [W-1:0]  track_y;
  logic [SW-1:0] sum_x;
  logic [SW-1:0] sum_y;
  logic [CW-1:0] inside_count;
  logic [CW-1:0] seen;
  logic [W-1:0]  quo_x;
  logic [W-1:0]  quo_y;
  logic [CW-1:0] rem_x;
  logic [CW-1:0] rem_y;

  logic          take;
  logic          in_box;
  logic [CW:0]   cnt_ext;
  logic [CW:0]   trial_x;
  logic [CW:0]   trial_y;
  logic          ge_x;
  logic          ge_y;
  logic [CW:0]   diff_x;
  logic [CW:0]   diff_y;
  logic [CW-1:0] rem_x_next;
  logic [CW-1:0] rem_y_next;

  logic [W-1:0]  mid_x;
  logic [W-1:0]  mid_y;
  logic          neg_x;
  logic          neg_y;
  logic [W-1:0]  mag_x;
  logic [W-1:0]  mag_y;
  ptct_pkg::move_cmd_t move_cmd;

  assign take = ctl.accum && item.point_valid && (seen < CW'(MAX_POINTS));
  assign in_box = (item.fixed_x > item.box_min_x) && (item.fixed_x < item.box_max_x) &&
                  (item.fixed_y > item.box_min_y) && (item.fixed_y < item.box_max_y);

  assign status.count_zero = (inside_count == '0);

  assign cnt_ext    = {1'b0, inside_count};
  assign trial_x    = {rem_x, quo_x[W-1]};
  assign trial_y    = {rem_y, quo_y[W-1]};
  assign ge_x       = (trial_x >= cnt_ext);
  assign ge_y       = (trial_y >= cnt_ext);
  assign diff_x     = trial_x - cnt_ext;
  assign diff_y     = trial_y - cnt_ext;
  assign rem_x_next = ge_x ? diff_x[CW-1:0] : trial_x[CW-1:0];
  assign rem_y_next = ge_y ? diff_y[CW-1:0] : trial_y[CW-1:0];

  assign mid_x = frame_width >> 1;
  assign mid_y = frame_height >> 1;
  assign neg_x = (track_x < mid_x);
  assign neg_y = (track_y < mid_y);
  assign mag_x = neg_x ? (mid_x - track_x) : (track_x - mid_x);
  assign mag_y = neg_y ? (mid_y - track_y) : (track_y - mid_y);

  always_comb begin
    if (mag_x > dead_radius) begin
      move_cmd = neg_x ? ptct_pkg::CMD_LEFT : ptct_pkg::CMD_RIGHT;
    end else if (mag_y > dead_radius) begin
      move_cmd = neg_y ? ptct_pkg::CMD_UP : ptct_pkg::CMD_DOWN;
    end else begin
      move_cmd = ptct_pkg::CMD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size    <= ptct_pkg::STEP_SIZE_RST;
      dead_radius  <= ptct_pkg::DEAD_RADIUS_RST;
      frame_width  <= ptct_pkg::FRAME_WIDTH_RST;
      frame_height <= ptct_pkg::FRAME_HEIGHT_RST;
      track_x      <= ptct_pkg::TRACK_X_RST;
      track_y      <= ptct_pkg::TRACK_Y_RST;
      sum_x        <= '0;
      sum_y        <= '0;
      inside_count <= '0;
      seen         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (ptct_pkg::cfg_reg_t'(cfg_index))
          ptct_pkg::REG_STEP_SIZE:    step_size    <= cfg_data;
          ptct_pkg::REG_DEAD_RADIUS:  dead_radius  <= cfg_data;
          ptct_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          ptct_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        seen <= seen + CW'(1);
        if (in_box) begin
          sum_x        <= sum_x + SW'(item.moving_x);
          sum_y        <= sum_y + SW'(item.moving_y);
          inside_count <= inside_count + CW'(1);
        end
      end
      if (ctl.apply) begin
        track_x <= ptct_pkg::approach(track_x, quo_x, step_size);
        track_y <= ptct_pkg::approach(track_y, quo_y, step_size);
      end
      if (ctl.emit) begin
        sum_x        <= '0;
        sum_y        <= '0;
        inside_count <= '0;
        seen         <= '0;
      end
      result_valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      rem_x <= sum_x[SW-1:W];
      rem_y <= sum_y[SW-1:W];
      quo_x <= sum_x[W-1:0];
      quo_y <= sum_y[W-1:0];
    end else if (ctl.div_step) begin
      rem_x <= rem_x_next;
      rem_y <= rem_y_next;
      quo_x <= {quo_x[W-2:0], ge_x};
      quo_y <= {quo_y[W-2:0], ge_y};
    end
    if (ctl.emit) begin
      result.centre_x <= track_x;
      result.centre_y <= track_y;
      result.move_cmd <= move_cmd;
    end
  end

  `PTCT_ASSERT(a_emit_strobe, clk, rst, ctl.emit |=> result_valid)
  `PTCT_ASSERT(a_single_beat, clk, rst, result_valid |=> !result_valid)
  `PTCT_ASSERT(a_cleared_after_box, clk, rst, ctl.emit |=> (seen == '0 && inside_count == '0))
  `PTCT_ASSERT_ALWAYS(a_count_within_seen, clk, rst || (inside_count <= seen))

endmodule

>>> hdl/pan_tilt_centroid_tracker.sv
// Match items are taken one per clock while busy is low (start high, busy low). The item with
// last_of_box set closes the box; busy then stays high through a load state, the bit-serial
// steps of two dividers that average x and y in parallel, an apply state that steps the centre
// and an emit state that forms the command if a point fell inside the box, else through the
// load and emit states only. The result beat appears in the cycle after the emit state, for one
// cycle only, marked by result_valid; the receiver cannot stall it and must take it then.
// Configuration writes are always accepted (cfg_ready is tied high) and take effect at once.
module pan_tilt_centroid_tracker #(
  parameter int MAX_POINTS = ptct_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  ptct_pkg::item_t                item,
  output ptct_pkg::result_t              result,
  output logic                           result_valid,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ptct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptct_pkg::COORD_W-1:0]   cfg_data
);

  ptct_pkg::ctrl_t      ctl;
  ptct_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  ptct_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_of_box (item.last_of_box),
    .status      (status),
    .busy        (busy),
    .ctl         (ctl)
  );

  ptct_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .ctl          (ctl),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
